// ===== rtl/tskf_pkg.sv =====
// Shared constants, register codes and the sample scaling function of the
// three-axis scalar Kalman filter. No dependencies.
package tskf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;
  localparam int GAIN_BITS   = 16;
  localparam int EST_BITS    = 24;
  localparam int VAR_BITS    = 32;
  localparam int REG_BITS    = 24;

  // Gain runs from 0 to exactly one, so it needs one integer bit.
  localparam int GAIN_W = GAIN_BITS + 1;
  localparam int DIFF_W = EST_BITS + 1;
  localparam int DEN_W  = VAR_BITS + 1;
  localparam int CNT_W  = $clog2(GAIN_W);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_SEL_BIT = 2;

  localparam logic REG_MEAS_NOISE = 1'b0;
  localparam logic REG_PROC_NOISE = 1'b1;

  localparam logic [REG_BITS-1:0] MEAS_NOISE_RST = REG_BITS'(102400);
  localparam logic [REG_BITS-1:0] PROC_NOISE_RST = REG_BITS'(2560);

  localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {GAIN_BITS{1'b0}}};

  localparam int TGT_W = SAMPLE_BITS + FRAC_BITS;
  localparam int CMP_W = ((TGT_W > EST_BITS) ? TGT_W : EST_BITS) + 1;

  // Scales a raw sample to the estimate format and clamps it to that range.
  function automatic logic signed [EST_BITS-1:0] scale_sample(
    input logic signed [SAMPLE_BITS-1:0] s
  );
    logic signed [CMP_W-1:0] v;
    logic signed [CMP_W-1:0] hi;
    logic signed [CMP_W-1:0] lo;
    v  = CMP_W'(s) <<< FRAC_BITS;
    hi = (CMP_W'(1) <<< (EST_BITS - 1)) - CMP_W'(1);
    lo = -hi - CMP_W'(1);
    if (v > hi) begin
      return EST_BITS'(hi);
    end else if (v < lo) begin
      return EST_BITS'(lo);
    end
    return EST_BITS'(v);
  endfunction

endpackage

// ===== rtl/tskf_intf.sv =====
// Valid/ready channel interfaces for the sample and estimate streams.
// Depends on tskf_pkg for the field widths.
interface tskf_sample_if import tskf_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_x;
  logic signed [SAMPLE_BITS-1:0] sample_y;
  logic signed [SAMPLE_BITS-1:0] sample_z;

  modport source (output valid, output sample_x, output sample_y, output sample_z,
                  input ready);
  modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                  output ready);
endinterface

interface tskf_estimate_if import tskf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [EST_BITS-1:0] estimate_x;
  logic signed [EST_BITS-1:0] estimate_y;
  logic signed [EST_BITS-1:0] estimate_z;

  modport source (output valid, output estimate_x, output estimate_y, output estimate_z,
                  input ready);
  modport sink   (input valid, input estimate_x, input estimate_y, input estimate_z,
                  output ready);
endinterface

// ===== rtl/three_axis_scalar_kalman_top.sv =====
// Three-axis scalar Kalman filter: bit-serial gain divider and shift-add
// multipliers. Depends on tskf_pkg and the channel interfaces in tskf_intf.sv.
//
//   Channel      Direction  Handshake              Beat carries
//   sample_i     in         valid/ready            sample_x, sample_y, sample_z
//   estimate_o   out        valid/ready            estimate_x, estimate_y, estimate_z
//   APB port     in/out     psel/penable/pready    measurement_noise, process_noise
//
// Each sample beat runs as a sequence: the sample is accepted, the restoring
// divider forms the gain one quotient bit per cycle, the four shift-add
// multipliers consume one gain bit per cycle, and a final step writes back
// the state and loads the output register.
// Reset is asynchronous and active low; it clears the estimates and the
// variance and restores the default noise settings, with no clearing pass.
// The output register lets a finished beat wait while the next sample is
// accepted; only the write-back step stalls while that register is full.
module three_axis_scalar_kalman_top import tskf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tskf_sample_if.sink           sample_i,
  tskf_estimate_if.source       estimate_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Configuration and filter state.
  logic [REG_BITS-1:0]        meas_q, proc_q;
  logic [VAR_BITS-1:0]        var_q;
  logic signed [EST_BITS-1:0] est_q [3];

  // Output register.
  logic signed [EST_BITS-1:0] out_q [3];
  logic                       out_valid_q;

  // Working registers of the current beat.
  logic              neg_q [3];
  logic [DIFF_W-1:0] mag_q [3];
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;
  logic [GAIN_W-1:0] num_q, quo_q;
  logic [GAIN_W-1:0] gsh_q, hsh_q;
  logic [DIFF_W:0]   acc_hi_q [3];
  logic [GAIN_W-1:0] acc_lo_q [3];
  logic [VAR_BITS:0] vhi_q;
  logic [GAIN_W-1:0] vlo_q;

  logic in_fire, out_free, step_last, wb_fire, cfg_wr;

  assign in_fire   = sample_i.valid && sample_i.ready;
  assign out_free  = !out_valid_q || estimate_o.ready;
  assign step_last = (cnt_q == CNT_W'(GAIN_W - 1));
  assign wb_fire   = (state_q == S_DONE) && out_free;
  assign cfg_wr    = psel && penable && pwrite;

  assign sample_i.ready = (state_q == S_IDLE);

  // Targets and differences are formed as the sample is accepted.
  logic signed [SAMPLE_BITS-1:0] samp [3];
  logic signed [EST_BITS-1:0]    tgt  [3];
  logic signed [DIFF_W-1:0]      diff [3];
  logic [DIFF_W-1:0]             mag  [3];

  assign samp[0] = sample_i.sample_x;
  assign samp[1] = sample_i.sample_y;
  assign samp[2] = sample_i.sample_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tgt[i]  = scale_sample(samp[i]);
      diff[i] = DIFF_W'(tgt[i]) - DIFF_W'(est_q[i]);
      mag[i]  = diff[i][DIFF_W-1] ? DIFF_W'(-diff[i]) : DIFF_W'(diff[i]);
    end
  end

  // One restoring division step per cycle: the quotient is (P << GAIN_BITS)
  // over P + R, and the numerator bits are fed in from num_q.
  logic [DEN_W:0]    rem_sh, rem_sub;
  logic              rem_ge, den_zero;
  logic [GAIN_W-1:0] gain;

  assign rem_sh   = {rem_q, num_q[GAIN_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, den_q});
  assign rem_sub  = rem_sh - {1'b0, den_q};
  assign den_zero = (den_q == '0);
  assign gain     = den_zero ? '0 : {quo_q[GAIN_W-2:0], rem_ge};

  // Shift-add products, least significant multiplier bit first.
  logic [DIFF_W:0]   msum [3];
  logic [VAR_BITS:0] vsum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      msum[i] = acc_hi_q[i] + (gsh_q[0] ? {1'b0, mag_q[i]} : '0);
    end
    vsum = vhi_q + (hsh_q[0] ? {1'b0, var_q} : '0);
  end

  // Write-back: round the products and apply them.
  logic [DIFF_W:0]            step    [3];
  logic [DIFF_W:0]            est_ext [3];
  logic [DIFF_W:0]            est_sum [3];
  logic signed [EST_BITS-1:0] est_new [3];
  logic [VAR_BITS+1:0]        var_sum;
  logic [VAR_BITS-1:0]        var_new;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      step[i]    = {acc_hi_q[i][DIFF_W-1:0], acc_lo_q[i][GAIN_BITS]}
                 + (DIFF_W + 1)'(acc_lo_q[i][GAIN_BITS-1]);
      est_ext[i] = {{2{est_q[i][EST_BITS-1]}}, est_q[i]};
      est_sum[i] = neg_q[i] ? (est_ext[i] - step[i]) : (est_ext[i] + step[i]);
      est_new[i] = est_sum[i][EST_BITS-1:0];
    end
    var_sum = {1'b0, vhi_q[VAR_BITS-1:0], vlo_q[GAIN_BITS]}
            + (VAR_BITS + 2)'(vlo_q[GAIN_BITS-1])
            + (VAR_BITS + 2)'(proc_q);
    var_new = (var_sum[VAR_BITS+1:VAR_BITS] != 2'b00) ? '1 : var_sum[VAR_BITS-1:0];
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_DIV;
          cnt_d   = '0;
        end
      end
      S_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (step_last) begin
          state_d = S_MUL;
          cnt_d   = '0;
        end
      end
      S_MUL: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (step_last) begin
          state_d = S_DONE;
          cnt_d   = '0;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      meas_q      <= MEAS_NOISE_RST;
      proc_q      <= PROC_NOISE_RST;
      var_q       <= '0;
      for (int i = 0; i < 3; i++) begin
        est_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (wb_fire) begin
        out_valid_q <= 1'b1;
      end else if (estimate_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        if (paddr[REG_SEL_BIT] == REG_MEAS_NOISE) begin
          meas_q <= pwdata[REG_BITS-1:0];
        end else begin
          proc_q <= pwdata[REG_BITS-1:0];
        end
      end
      if (wb_fire) begin
        var_q <= var_new;
        for (int i = 0; i < 3; i++) begin
          est_q[i] <= est_new[i];
        end
      end
    end
  end

  // Datapath registers; these need no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      den_q <= {1'b0, var_q} + DEN_W'(meas_q);
      rem_q <= DEN_W'(var_q >> 1);
      num_q <= {var_q[0], {GAIN_BITS{1'b0}}};
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= diff[i][DIFF_W-1];
        mag_q[i] <= mag[i];
      end
    end
    if (state_q == S_DIV) begin
      rem_q <= rem_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      num_q <= {num_q[GAIN_W-2:0], 1'b0};
      quo_q <= {quo_q[GAIN_W-2:0], rem_ge};
      if (step_last) begin
        gsh_q <= gain;
        hsh_q <= GAIN_ONE - gain;
        vhi_q <= '0;
        vlo_q <= '0;
        for (int i = 0; i < 3; i++) begin
          acc_hi_q[i] <= '0;
          acc_lo_q[i] <= '0;
        end
      end
    end
    if (state_q == S_MUL) begin
      gsh_q <= gsh_q >> 1;
      hsh_q <= hsh_q >> 1;
      vhi_q <= {1'b0, vsum[VAR_BITS:1]};
      vlo_q <= {vsum[0], vlo_q[GAIN_W-1:1]};
      for (int i = 0; i < 3; i++) begin
        acc_hi_q[i] <= {1'b0, msum[i][DIFF_W:1]};
        acc_lo_q[i] <= {msum[i][0], acc_lo_q[i][GAIN_W-1:1]};
      end
    end
    if (wb_fire) begin
      for (int i = 0; i < 3; i++) begin
        out_q[i] <= est_new[i];
      end
    end
  end

  assign estimate_o.valid      = out_valid_q;
  assign estimate_o.estimate_x = out_q[0];
  assign estimate_o.estimate_y = out_q[1];
  assign estimate_o.estimate_z = out_q[2];

  // Register read-back; both registers sit in the low bits of the data bus.
  assign pready = 1'b1;
  assign prdata = (paddr[REG_SEL_BIT] == REG_PROC_NOISE) ? APB_DATA_W'(proc_q)
                                                         : APB_DATA_W'(meas_q);

  // An accepted sample always starts the divider on the next cycle.
  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_DIV))
    else $error("accepted sample did not start the divider");

  // The step counter never runs past the last quotient or multiplier bit.
  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV || state_q == S_MUL) |-> (cnt_q <= CNT_W'(GAIN_W - 1)))
    else $error("step counter overran");

  // The gain can never exceed one.
  a_gain_le_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && step_last) |-> (gain <= GAIN_ONE))
    else $error("gain above one");

  // After a write-back the variance is at least the process noise.
  a_var_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_fire |=> (var_q >= VAR_BITS'($past(proc_q))))
    else $error("variance fell below the process noise");

endmodule
